// File: rtl/tap_tempo_estimator_core_defines.svh
// Assertion macros shared by the checker files of the tap tempo estimator.
// Each macro expects i_clk and i_rst_n to exist in the scope where it is used.
`ifndef TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH
`define TAP_TEMPO_ESTIMATOR_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define TTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked through reset.
`define TTE_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/tte_pkg.sv
// Package of the tap tempo estimator: field widths, register indexes,
// result codes and the request type of the shared arithmetic unit. No dependencies.
package tte_pkg;

    // Field widths fixed by the interface.
    localparam int TIME_W    = 32;
    localparam int BEAT_W    = 16;
    localparam int TAPS_W    = 3;
    localparam int KIND_W    = 3;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int ALU_W     = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BEAT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT  = 3'd4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd3000;
    localparam logic [CFG_W-1:0] BOUNCE_RST   = 16'd50;
    localparam logic [CFG_W-1:0] MIN_BEAT_RST = 16'd200;
    localparam logic [CFG_W-1:0] MAX_BEAT_RST = 16'd1500;
    localparam logic [CFG_W-1:0] DEFAULT_RST  = 16'd500;

    // Classification of a processed item.
    typedef enum logic [KIND_W-1:0] {
        KIND_FIRST   = 3'd0,
        KIND_RESTART = 3'd1,
        KIND_BOUNCE  = 3'd2,
        KIND_ACCEPT  = 3'd3,
        KIND_HOLD    = 3'd4
    } t_kind;

    // Operation of the shared adder.
    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    // One request to the shared adder.
    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

endpackage

// File: rtl/tte_in_if.sv
// Input channel of the tap tempo estimator: valid/ready and one tap event.
// Depends on tte_pkg for the field widths.
interface tte_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [tte_pkg::TIME_W-1:0] now_ms;

    modport source (output valid, output func, output now_ms, input ready);
    modport sink (input valid, input func, input now_ms, output ready);
endinterface

// File: rtl/tte_out_if.sv
// Output channel of the tap tempo estimator: valid/ready and one result.
// Depends on tte_pkg for the field widths.
interface tte_out_if;
    logic                       valid;
    logic                       ready;
    logic [tte_pkg::BEAT_W-1:0] beat_ms;
    logic [tte_pkg::TAPS_W-1:0] taps_held;
    logic [tte_pkg::KIND_W-1:0] tap_kind;

    modport source (output valid, output beat_ms, output taps_held, output tap_kind,
                    input ready);
    modport sink (input valid, input beat_ms, input taps_held, input tap_kind,
                  output ready);
endinterface

// File: rtl/tte_alu.sv
// Shared 32-bit adder/subtractor of the tap tempo estimator, with a less-than flag.
// Depends on tte_pkg for the request type.
module tte_alu (
    input  tte_pkg::t_alu_req          i_req,
    output logic [tte_pkg::ALU_W-1:0]  o_res,
    output logic                       o_lt
);
    import tte_pkg::*;

    logic [ALU_W:0]   sum;
    logic [ALU_W-1:0] b_op;
    logic             cin;

    // Subtraction adds the inverted operand plus one; a missing carry means a < b.
    always_comb begin
        case (i_req.op)
            ALU_SUB: begin
                b_op = ~i_req.b;
                cin  = 1'b1;
            end
            default: begin
                b_op = i_req.b;
                cin  = 1'b0;
            end
        endcase
        sum   = {1'b0, i_req.a} + {1'b0, b_op} + (ALU_W + 1)'(cin);
        o_res = sum[ALU_W-1:0];
        o_lt  = (i_req.op == ALU_SUB) && !sum[ALU_W];
    end

endmodule

// File: rtl/tte_window.sv
// Sliding window of tap intervals: a shift line with the newest entry on top.
// Depends on tte_pkg for the interval width.
module tte_window #(
    parameter  int WINDOW_TAPS = 4,
    localparam int IDX_W       = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1
) (
    input  logic                       i_clk,
    input  logic                       i_push,
    input  logic [tte_pkg::BEAT_W-1:0] i_data,
    input  logic [IDX_W-1:0]           i_rd_idx,
    output logic [tte_pkg::BEAT_W-1:0] o_rd_data
);
    import tte_pkg::*;

    logic [BEAT_W-1:0] r_win [WINDOW_TAPS];

    // A push drops the oldest entry and appends the new interval at the top.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int i = 0; i < WINDOW_TAPS - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
            r_win[WINDOW_TAPS - 1] <= i_data;
        end
    end

    // One read port, addressed by the summing sequencer.
    assign o_rd_data = r_win[i_rd_idx];

endmodule

// File: rtl/tap_tempo_estimator_core.sv
// Top level of the tap tempo estimator: sequencer, configuration registers and state.
// Depends on tte_pkg, tte_in_if, tte_out_if, tte_alu and tte_window.
//
// Each tap or hold-reset transfer is worked through by a small sequencer that drives
// one shared 32-bit adder/subtractor, and the input is not ready until that item
// is finished. A hold-reset or first tap ends after the evaluation step, a timeout
// restart after the timeout test, a bounce after the bounce test; for an accepted
// interval the adder sums the window one entry per cycle and then divides by N, the
// number of intervals in the window, with a restoring division of one quotient bit
// per cycle over the 18-bit sum (16 plus log2 of WINDOW_TAPS rounded up, in general),
// and the result is clamped to the beat limits. A finished result sits in an output
// register, so the next tap can be taken while the previous result still waits;
// while the receiver stalls with that register full, the next item is held in its
// last state until the register is free.
module tap_tempo_estimator_core #(
    parameter int WINDOW_TAPS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tte_in_if.sink                        i_tap,
    tte_out_if.source                     o_beat,
    input  logic                          i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tte_pkg::CFG_W-1:0]     i_cfg_data
);
    import tte_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW_TAPS + 1);
    localparam int IDX_W  = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
    localparam int SUM_W  = BEAT_W + IDX_W;
    localparam int DIV_CW = $clog2(SUM_W + 1);
    localparam int REM_W  = CNT_W + 1;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_TOUT  = 9'b000000100,
        S_BNC   = 9'b000001000,
        S_SUM   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_CLMIN = 9'b001000000,
        S_CLMAX = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state             r_state;

    // Configuration registers.
    logic [CFG_W-1:0]   r_timeout;
    logic [CFG_W-1:0]   r_bounce;
    logic [CFG_W-1:0]   r_min;
    logic [CFG_W-1:0]   r_max;
    logic [CFG_W-1:0]   r_default;

    // Estimator state.
    logic               r_awaiting;
    logic [TIME_W-1:0]  r_last;
    logic [CNT_W-1:0]   r_count;
    logic [BEAT_W-1:0]  r_beat;

    // Working registers of the item in progress.
    logic               r_func;
    logic [TIME_W-1:0]  r_now;
    logic [TIME_W-1:0]  r_delta;
    logic [SUM_W-1:0]   r_acc;
    logic [REM_W-1:0]   r_rem;
    logic [CNT_W-1:0]   r_k;
    logic [DIV_CW-1:0]  r_step;
    t_kind              r_kind;

    // Output register.
    logic               r_out_valid;
    logic [BEAT_W-1:0]  r_out_beat;
    logic [TAPS_W-1:0]  r_out_taps;
    t_kind              r_out_kind;

    t_alu_req           alu_req;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_lt;

    logic               win_push;
    logic [CNT_W-1:0]   win_idx_full;
    logic [BEAT_W-1:0]  win_rd;
    logic [REM_W-1:0]   div_trial;
    logic               out_load;

    // Shared arithmetic unit.
    tte_alu u_alu (
        .i_req (alu_req),
        .o_res (alu_res),
        .o_lt  (alu_lt)
    );

    // Interval window; entries are read from the newest downward.
    assign win_push     = (r_state == S_BNC) && alu_lt;
    assign win_idx_full = CNT_W'(WINDOW_TAPS - 1) - r_k;

    tte_window #(
        .WINDOW_TAPS (WINDOW_TAPS)
    ) u_window (
        .i_clk     (i_clk),
        .i_push    (win_push),
        .i_data    (r_delta[BEAT_W-1:0]),
        .i_rd_idx  (win_idx_full[IDX_W-1:0]),
        .o_rd_data (win_rd)
    );

    // Partial remainder with the next dividend bit shifted in.
    assign div_trial = {r_rem[REM_W-2:0], r_acc[SUM_W-1]};

    // Operand selection for the shared unit, one use per sequencer state.
    always_comb begin
        alu_req = '{op: ALU_SUB, a: '0, b: '0};
        unique case (r_state)
            S_EVAL: begin
                alu_req.a = r_now;
                alu_req.b = r_last;
            end
            S_TOUT: begin
                alu_req.a = ALU_W'(r_timeout);
                alu_req.b = r_delta;
            end
            S_BNC: begin
                alu_req.a = ALU_W'(r_bounce);
                alu_req.b = r_delta;
            end
            S_SUM: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(r_acc);
                alu_req.b  = ALU_W'(win_rd);
            end
            S_DIV: begin
                alu_req.a = ALU_W'(div_trial);
                alu_req.b = ALU_W'(r_count);
            end
            S_CLMIN: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(r_min);
            end
            S_CLMAX: begin
                alu_req.a = ALU_W'(r_max);
                alu_req.b = ALU_W'(r_acc);
            end
            default: ;
        endcase
    end

    // The finished result moves to the output register once it is free.
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_beat.ready);

    // Sequencer, configuration writes and estimator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timeout   <= TIMEOUT_RST;
            r_bounce    <= BOUNCE_RST;
            r_min       <= MIN_BEAT_RST;
            r_max       <= MAX_BEAT_RST;
            r_default   <= DEFAULT_RST;
            r_awaiting  <= 1'b1;
            r_last      <= '0;
            r_count     <= '0;
            r_beat      <= DEFAULT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMEOUT:  r_timeout <= i_cfg_data;
                    CFG_BOUNCE:   r_bounce  <= i_cfg_data;
                    CFG_MIN_BEAT: r_min     <= i_cfg_data;
                    CFG_MAX_BEAT: r_max     <= i_cfg_data;
                    CFG_DEFAULT:  r_default <= i_cfg_data;
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_beat.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_tap.valid) begin
                        r_func  <= i_tap.func;
                        r_now   <= i_tap.now_ms;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_func) begin
                        r_beat     <= r_default;
                        r_awaiting <= 1'b1;
                        r_count    <= '0;
                        r_kind     <= KIND_HOLD;
                        r_state    <= S_DONE;
                    end else if (r_awaiting) begin
                        r_awaiting <= 1'b0;
                        r_count    <= '0;
                        r_last     <= r_now;
                        r_kind     <= KIND_FIRST;
                        r_state    <= S_DONE;
                    end else begin
                        r_delta <= alu_res;
                        r_state <= S_TOUT;
                    end
                end
                S_TOUT: begin
                    // The interval is above the timeout when timeout < interval.
                    if (alu_lt) begin
                        r_count <= '0;
                        r_last  <= r_now;
                        r_kind  <= KIND_RESTART;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_BNC;
                    end
                end
                S_BNC: begin
                    if (!alu_lt) begin
                        r_kind  <= KIND_BOUNCE;
                        r_state <= S_DONE;
                    end else begin
                        if (r_count != CNT_W'(WINDOW_TAPS)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        r_last  <= r_now;
                        r_kind  <= KIND_ACCEPT;
                        r_acc   <= '0;
                        r_k     <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_acc <= alu_res[SUM_W-1:0];
                    r_k   <= r_k + CNT_W'(1);
                    if ((r_k + CNT_W'(1)) == r_count) begin
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // Restoring division: one quotient bit enters at the bottom.
                    r_acc  <= {r_acc[SUM_W-2:0], !alu_lt};
                    r_rem  <= alu_lt ? div_trial : alu_res[REM_W-1:0];
                    r_step <= r_step + DIV_CW'(1);
                    if (r_step == DIV_CW'(SUM_W - 1)) begin
                        r_state <= S_CLMIN;
                    end
                end
                S_CLMIN: begin
                    // The lower bound is tested first and wins where both bounds apply on an inverted range.
                    if (alu_lt) begin
                        r_beat  <= r_min;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_CLMAX;
                    end
                end
                S_CLMAX: begin
                    r_beat  <= alu_lt ? r_max : r_acc[BEAT_W-1:0];
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output payload, captured with the valid flag.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_beat <= r_beat;
            r_out_taps <= TAPS_W'(r_count);
            r_out_kind <= r_kind;
        end
    end

    assign i_tap.ready      = (r_state == S_IDLE);
    assign o_beat.valid     = r_out_valid;
    assign o_beat.beat_ms   = r_out_beat;
    assign o_beat.taps_held = r_out_taps;
    assign o_beat.tap_kind  = r_out_kind;

endmodule

// File: rtl/tte_checker.sv
// Port-level checks of the tap tempo estimator and their bind to the top level.
// Depends on tte_pkg and tap_tempo_estimator_core_defines.svh.
`include "tap_tempo_estimator_core_defines.svh"

module tte_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [tte_pkg::BEAT_W-1:0] i_beat_ms,
    input logic [tte_pkg::TAPS_W-1:0] i_taps_held,
    input logic [tte_pkg::KIND_W-1:0] i_tap_kind
);
    import tte_pkg::*;

    // A stalled result keeps its valid flag and its payload.
    `TTE_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_beat_ms) && $stable(i_taps_held) && $stable(i_tap_kind), "stalled result changed")

    // The block works on one item at a time, so a transfer leaves the input busy.
    `TTE_ASSERT(a_busy_after_in, i_in_valid && i_in_ready |=> !i_in_ready, "input ready right after a transfer")

    // Reset empties the output register.
    `TTE_ASSERT_RST(a_rst_clears_out, !i_rst_n |=> !i_out_valid, "output valid after reset")

endmodule

bind tap_tempo_estimator_core tte_checker u_tte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_tap.valid),
    .i_in_ready  (i_tap.ready),
    .i_out_valid (o_beat.valid),
    .i_out_ready (o_beat.ready),
    .i_beat_ms   (o_beat.beat_ms),
    .i_taps_held (o_beat.taps_held),
    .i_tap_kind  (o_beat.tap_kind)
);

// File: tb/tb_tap_tempo_estimator_core.sv
// Testbench of tap_tempo_estimator_core: directed and random tap streams with random
// idling on both channels, each result checked against a behavioral beat estimator.
// Depends on tte_pkg, tte_in_if, tte_out_if and the RTL of the block.
module tb_tap_tempo_estimator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tte_pkg::*;

    localparam int WINDOW_TAPS   = 4;
    localparam int LIMIT_CYCLES  = 800000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS   = 170;

    // One expected result of the block.
    typedef struct packed {
        logic [BEAT_W-1:0] beat;
        logic [TAPS_W-1:0] taps;
        t_kind             kind;
    } t_beat_result;

    // Stall patterns of the result receiver.
    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_MOSTLY,
        RX_PERIODIC
    } t_rx_mode;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tte_in_if  tap_if();
    tte_out_if beat_if();

    // Register copies and estimator state of the prediction.
    logic [CFG_W-1:0]  cfg_timeout;
    logic [CFG_W-1:0]  cfg_bounce;
    logic [CFG_W-1:0]  cfg_min_beat;
    logic [CFG_W-1:0]  cfg_max_beat;
    logic [CFG_W-1:0]  cfg_default;
    logic              est_waiting_first;
    logic [TIME_W-1:0] est_last_tap;
    logic [BEAT_W-1:0] est_window [WINDOW_TAPS];
    int                est_count;
    logic [BEAT_W-1:0] est_beat;

    t_beat_result pending_beats [$];
    t_beat_result beat_want;
    int           beat_errors = 0;

    // Sender burst state.
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // Receiver stall state.
    int       rx_hold_request = 0;
    int       rx_hold_left    = 0;
    int       rx_mode_left    = 0;
    int       rx_tick         = 0;
    t_rx_mode rx_mode         = RX_ALWAYS;

    int watchdog_cycles;

    tap_tempo_estimator_core #(
        .WINDOW_TAPS(WINDOW_TAPS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tap      (tap_if),
        .o_beat     (beat_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Clamp an average to the beat limits; the lower bound wins where both apply.
    function automatic logic [BEAT_W-1:0] clamp_to_limits(input logic [31:0] avg);
        if (avg < cfg_min_beat) return cfg_min_beat;
        if (avg > cfg_max_beat) return cfg_max_beat;
        return avg[BEAT_W-1:0];
    endfunction

    // Advance the estimator by one accepted item and queue the result it gives.
    function automatic void predict_beat(input logic hold, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] delta;
        logic [31:0]       sum;
        t_kind             kind;
        t_beat_result      res;
        delta = now - est_last_tap;
        if (hold) begin
            est_beat          = cfg_default;
            est_waiting_first = 1'b1;
            est_count         = 0;
            kind              = KIND_HOLD;
        end else if (est_waiting_first) begin
            est_waiting_first = 1'b0;
            est_count         = 0;
            est_last_tap      = now;
            kind              = KIND_FIRST;
        end else if (delta > cfg_timeout) begin
            est_count    = 0;
            est_last_tap = now;
            kind         = KIND_RESTART;
        end else if (delta <= cfg_bounce) begin
            kind = KIND_BOUNCE;
        end else begin
            // Append the interval, dropping the oldest one when the window is full.
            if (est_count < WINDOW_TAPS) begin
                est_window[est_count] = delta[BEAT_W-1:0];
                est_count++;
            end else begin
                for (int i = 0; i < WINDOW_TAPS - 1; i++) est_window[i] = est_window[i + 1];
                est_window[WINDOW_TAPS-1] = delta[BEAT_W-1:0];
            end
            sum = '0;
            for (int i = 0; i < est_count; i++) sum += est_window[i];
            est_beat     = clamp_to_limits(sum / est_count);
            est_last_tap = now;
            kind         = KIND_ACCEPT;
        end
        res.beat = est_beat;
        res.taps = TAPS_W'(est_count);
        res.kind = kind;
        pending_beats.push_back(res);
    endfunction

    // Interval for the next tap: mostly inside the accepted band, plus edges and noise.
    function automatic logic [TIME_W-1:0] tap_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) return TIME_W'(cfg_bounce);
        if (roll < 12) return cfg_bounce + 1;
        if (roll < 16) return TIME_W'(cfg_timeout);
        if (roll < 20) return cfg_timeout + 1;
        if (roll < 30) return $urandom_range(0, cfg_bounce);
        if (roll < 35) return $urandom;
        if (cfg_bounce < cfg_timeout) return $urandom_range(cfg_bounce + 1, cfg_timeout);
        return $urandom_range(0, 65535);
    endfunction

    // Offer one item, wait for its transfer, then maybe idle before the next one.
    task automatic send_tap(input logic hold, input logic [TIME_W-1:0] now);
        tap_if.valid  <= 1'b1;
        tap_if.func   <= hold;
        tap_if.now_ms <= now;
        @(posedge i_clk);
        while (tap_if.ready !== 1'b1) @(posedge i_clk);
        predict_beat(hold, now);
        if (gaps_on && burst_left == 0) begin
            tap_if.valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 5);
        end else if (burst_left > 0) begin
            burst_left--;
        end
    endtask

    // Random taps timed from the last recorded tap, with hold-resets and stray timestamps.
    task automatic run_taps(input int count);
        int                roll;
        logic [TIME_W-1:0] now;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                send_tap(1'b1, $urandom);
            end else begin
                now = (roll < 8) ? TIME_W'($urandom) : est_last_tap + tap_interval();
                send_tap(1'b0, now);
            end
        end
    endtask

    // Stop offering and wait until every expected result has come and the block settles.
    task automatic wait_for_beats();
        tap_if.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register and mirror it into the prediction.
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TIMEOUT:  cfg_timeout  = value;
            CFG_BOUNCE:   cfg_bounce   = value;
            CFG_MIN_BEAT: cfg_min_beat = value;
            CFG_MAX_BEAT: cfg_max_beat = value;
            CFG_DEFAULT:  cfg_default  = value;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input logic [CFG_W-1:0] timeout_val,
                                input logic [CFG_W-1:0] bounce_val,
                                input logic [CFG_W-1:0] min_val,
                                input logic [CFG_W-1:0] max_val,
                                input logic [CFG_W-1:0] dflt_val);
        write_cfg(CFG_TIMEOUT, timeout_val);
        write_cfg(CFG_BOUNCE, bounce_val);
        write_cfg(CFG_MIN_BEAT, min_val);
        write_cfg(CFG_MAX_BEAT, max_val);
        write_cfg(CFG_DEFAULT, dflt_val);
    endtask

    // Reset limits: first tap, bounce edges, window fill and slide, restart, both clamps,
    // hold-reset while armed, and an interval across the timestamp wrap.
    task automatic test_reset_limits();
        send_tap(1'b0, 32'd0);
        send_tap(1'b0, 32'd30);
        send_tap(1'b0, 32'd50);
        send_tap(1'b0, 32'd51);
        send_tap(1'b0, 32'd651);
        send_tap(1'b0, 32'd3651);
        send_tap(1'b0, 32'd4651);
        send_tap(1'b0, 32'd5451);
        send_tap(1'b0, 32'd8452);
        send_tap(1'b0, 32'd8452);
        send_tap(1'b0, 32'd9952);
        send_tap(1'b0, 32'd12752);
        send_tap(1'b1, 32'hFFFF_FFFF);
        send_tap(1'b1, 32'd0);
        send_tap(1'b0, 32'hFFFF_FFFF);
        send_tap(1'b0, 32'h0000_0100);
        send_tap(1'b0, 32'h0000_0164);
        send_tap(1'b1, 32'h5555_AAAA);
    endtask

    // Widest limits; the new default shows only after the next hold-reset.
    task automatic test_wide_limits();
        wait_for_beats();
        apply_limits(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'hFFFF);
        run_taps(200);
    endtask

    // Lower clamp above the upper one.
    task automatic test_inverted_clamp();
        wait_for_beats();
        apply_limits(16'd2000, 16'd20, 16'd1000, 16'd300, 16'd700);
        run_taps(150);
    endtask

    // Zero timeout and bounce: every tap but a first tap or a hold-reset restarts or bounces.
    task automatic test_zero_limits();
        wait_for_beats();
        apply_limits(16'd0, 16'd0, 16'd1, 16'd1, 16'd1);
        run_taps(60);
    endtask

    // The receiver holds off long while items keep coming, so the input stalls.
    task automatic test_stalled_output();
        wait_for_beats();
        apply_limits(TIMEOUT_RST, BOUNCE_RST, MIN_BEAT_RST, MAX_BEAT_RST, DEFAULT_RST);
        gaps_on = 1'b0;
        rx_hold_request = 400;
        run_taps(30);
        wait_for_beats();
        gaps_on = 1'b1;
    endtask

    // Several random settings, some with crossed clamps.
    task automatic test_random_limits();
        logic [CFG_W-1:0] t_val;
        logic [CFG_W-1:0] b_val;
        logic [CFG_W-1:0] lo_val;
        logic [CFG_W-1:0] hi_val;
        repeat (6) begin
            wait_for_beats();
            t_val  = CFG_W'($urandom_range(100, 5000));
            b_val  = CFG_W'($urandom_range(0, t_val / 3));
            lo_val = CFG_W'($urandom_range(1, 800));
            hi_val = CFG_W'(($urandom_range(0, 4) == 0) ? $urandom_range(1, lo_val)
                                                        : $urandom_range(lo_val, 4000));
            apply_limits(t_val, b_val, lo_val, hi_val, CFG_W'($urandom_range(1, 65535)));
            run_taps(PHASE_ITEMS);
        end
    endtask

    // Receiver ready: a long hold-off on request, otherwise a changing stall pattern.
    always @(posedge i_clk) begin
        rx_tick++;
        if (rx_hold_request != 0) begin
            rx_hold_left    = rx_hold_request;
            rx_hold_request = 0;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            beat_if.ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 160);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                RX_ALWAYS:   beat_if.ready <= 1'b1;
                RX_HALF:     beat_if.ready <= ($urandom_range(0, 99) < 50);
                RX_MOSTLY:   beat_if.ready <= ($urandom_range(0, 99) < 85);
                RX_PERIODIC: beat_if.ready <= ((rx_tick % 7) < 4);
                default:     beat_if.ready <= 1'b1;
            endcase
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && beat_if.valid === 1'b1 && beat_if.ready === 1'b1) begin
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected result beat_ms=%0d taps_held=%0d tap_kind=%0d",
                         $time, beat_if.beat_ms, beat_if.taps_held, beat_if.tap_kind);
                beat_errors++;
            end else begin
                beat_want = pending_beats.pop_front();
                if (beat_if.beat_ms !== beat_want.beat) begin
                    $display("%0t: beat_ms expected %0d, got %0d",
                             $time, beat_want.beat, beat_if.beat_ms);
                    beat_errors++;
                end
                if (beat_if.taps_held !== beat_want.taps) begin
                    $display("%0t: taps_held expected %0d, got %0d",
                             $time, beat_want.taps, beat_if.taps_held);
                    beat_errors++;
                end
                if (beat_if.tap_kind !== beat_want.kind) begin
                    $display("%0t: tap_kind expected %0d, got %0d",
                             $time, beat_want.kind, beat_if.tap_kind);
                    beat_errors++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    initial begin
        for (watchdog_cycles = 0; watchdog_cycles < LIMIT_CYCLES; watchdog_cycles++)
            @(posedge i_clk);
        $display("[tap_tempo_estimator_core] ERROR");
        $finish;
    end

    // Reset, then the tests in turn.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_TIMEOUT;
        i_cfg_data    <= '0;
        tap_if.valid  <= 1'b0;
        tap_if.func   <= 1'b0;
        tap_if.now_ms <= '0;
        cfg_timeout       = TIMEOUT_RST;
        cfg_bounce        = BOUNCE_RST;
        cfg_min_beat      = MIN_BEAT_RST;
        cfg_max_beat      = MAX_BEAT_RST;
        cfg_default       = DEFAULT_RST;
        est_waiting_first = 1'b1;
        est_last_tap      = '0;
        est_count         = 0;
        est_beat          = DEFAULT_RST;
        foreach (est_window[i]) est_window[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_limits();
        test_wide_limits();
        test_inverted_clamp();
        test_zero_limits();
        test_stalled_output();
        test_random_limits();

        wait_for_beats();
        if (beat_errors == 0) begin
            $display("[tap_tempo_estimator_core] OK");
        end else begin
            $display("[tap_tempo_estimator_core] ERROR");
        end
        $finish;
    end

endmodule
